@@ rtl/rpnc_pkg.sv @@
// Package for the RPN stack calculator: constants, command and status codes,
// item types and the saturation helper. No dependencies.
package rpnc_pkg;

    localparam int STACK_DEPTH   = 64;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_VARS      = 26;

    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int VAR_AW  = $clog2(NUM_VARS);
    localparam int DVD_W   = 32 + FRACTION_BITS;
    localparam int ITER_W  = $clog2(DVD_W);

    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_ADD   = 4'd1;
    localparam logic [3:0] CMD_SUB   = 4'd2;
    localparam logic [3:0] CMD_MUL   = 4'd3;
    localparam logic [3:0] CMD_DIV   = 4'd4;
    localparam logic [3:0] CMD_MOD   = 4'd5;
    localparam logic [3:0] CMD_DUP   = 4'd6;
    localparam logic [3:0] CMD_SWAP  = 4'd7;
    localparam logic [3:0] CMD_STORE = 4'd8;
    localparam logic [3:0] CMD_LOAD  = 4'd9;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_UNSET = 3'd4;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] value;
        logic [4:0]         var_index;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] second_value;
        logic [6:0]         depth;
        logic [2:0]         status;
    } res_item_t;

    // Clamp a wide signed value into 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic ovf;
        ovf = (v[63:31] != {33{1'b0}}) && (v[63:31] != {33{1'b1}});
        if (!ovf)
            return v[31:0];
        else if (v[63])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

endpackage

@@ rtl/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: control sequencer, operand cache,
// iterative divider. Depends on rpnc_pkg and rpnc_ram.
//
// One command item in, one result item out, one item at a time. The operand
// stack lives in a 64 x 32 RAM and the variables in a 26 x 32 RAM, both with
// registered read data; the top two entries are mirrored in registers and
// re-read from the stack RAM after every command. Push, add, sub, dup, store,
// other command codes, a swap with fewer than two entries, a load of an unset
// variable and div or mod by zero go from execution straight to the refill
// states; mul, swap and a load that pushes first pass through S_MUL2, S_SWAP2
// or S_LOAD2; div and mod run the restoring divider, which retires one
// quotient bit per cycle over 48 bits (32 + fraction bits), then S_DIVFIN.
// No clearing pass is needed after reset: stack data are used only below the
// count and a variable only when its valid flag is set. A new command is
// accepted once the previous result has been handed to the output register.
module rpn_stack_calculator
    import rpnc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_MUL2   = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_DIVFIN = 4'd4;
    localparam logic [3:0] S_SWAP2  = 4'd5;
    localparam logic [3:0] S_LOAD2  = 4'd6;
    localparam logic [3:0] S_FILL1  = 4'd7;
    localparam logic [3:0] S_FILL2  = 4'd8;
    localparam logic [3:0] S_FILL3  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STACK_DEPTH);
    localparam logic [32:0]      FRAC_MASK = 33'((64'd1 << FRACTION_BITS) - 64'd1);

    // sequencer state
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       status_reg, status_next;
    cmd_item_t        item_reg;
    logic signed [31:0] top_reg, sec_reg;
    logic signed [63:0] prod_reg;
    logic [NUM_VARS-1:0] var_valid_reg;
    logic             res_valid_reg;
    res_item_t        res_reg;

    // divider
    logic [DVD_W-1:0]  div_q_reg, div_q_next;
    logic [31:0]       div_rem_reg, div_rem_next;
    logic [31:0]       div_dvs_reg;
    logic [ITER_W-1:0] div_ctr_reg;
    logic              div_neg_reg, div_mod_reg;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd_load;
    logic [31:0]       div_dvs_load;
    logic              div_neg_load;
    logic [32:0]       rem_sh;
    logic [32:0]       rem_diff;

    // memory ports
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [31:0]       st_wdata, st_rdata;
    logic              var_we;
    logic [31:0]       var_rdata;

    // operand views
    logic               has1, has2, idx_ok;
    logic [CNT_W-1:0]   cnt_m1, cnt_m2, cnt_after1, cnt_after2;
    logic signed [31:0] a_pop, b_pop;
    logic signed [32:0] a_int, b_int;
    logic signed [63:0] a_wide;
    logic [DVD_W-1:0]   a_scaled;
    logic signed [31:0] addsub;
    logic signed [31:0] mul_res;
    logic signed [31:0] div_res;
    logic signed [32:0] mod_rem;
    logic signed [31:0] mod_res;

    function automatic logic signed [32:0] int_part(input logic signed [31:0] x);
        logic signed [32:0] xe;
        xe = 33'(x);
        if (x[31])
            xe = xe + FRAC_MASK;
        return xe >>> FRACTION_BITS;
    endfunction

    rpnc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rpnc_ram #(.WIDTH(32), .DEPTH(NUM_VARS)) u_var_ram (
        .clk   (clk),
        .we    (var_we),
        .waddr (VAR_AW'(item_reg.var_index)),
        .wdata (b_pop),
        .raddr (VAR_AW'(item_reg.var_index)),
        .rdata (var_rdata)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Operands come from the cached top two; missing entries read as zero.
    assign has1       = (count_reg != '0);
    assign has2       = (count_reg > CNT_W'(1));
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign cnt_m2     = count_reg - CNT_W'(2);
    assign cnt_after1 = has1 ? cnt_m1 : count_reg;
    assign cnt_after2 = has2 ? cnt_m2 : cnt_after1;
    assign b_pop      = has1 ? top_reg : '0;
    assign a_pop      = has2 ? sec_reg : '0;
    assign idx_ok     = (item_reg.var_index < 5'(NUM_VARS));
    assign a_int      = int_part(a_pop);
    assign b_int      = int_part(b_pop);

    assign addsub = sat32((item_reg.command == CMD_SUB) ? (64'(a_pop) - 64'(b_pop))
                                                        : (64'(a_pop) + 64'(b_pop)));
    assign mul_res = sat32(prod_reg >>> FRACTION_BITS);

    assign a_wide   = 64'(a_pop) <<< FRACTION_BITS;
    assign a_scaled = a_pop[31] ? DVD_W'(-a_wide) : DVD_W'(a_wide);

    // Quotient magnitude to signed, saturating; remainder takes dividend sign.
    always_comb
    begin
        if (!div_neg_reg)
            div_res = (div_q_reg > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                          : 32'(div_q_reg);
        else
            div_res = (div_q_reg > DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                            : 32'(-div_q_reg);
    end
    assign mod_rem = div_neg_reg ? -{1'b0, div_rem_reg} : {1'b0, div_rem_reg};
    assign mod_res = sat32(64'(mod_rem) <<< FRACTION_BITS);

    // One restoring step per cycle.
    assign rem_sh   = {div_rem_reg, div_q_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_dvs_reg};
    always_comb
    begin
        if (!rem_diff[32])
        begin
            div_rem_next = rem_diff[31:0];
            div_q_next   = {div_q_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            div_rem_next = rem_sh[31:0];
            div_q_next   = {div_q_reg[DVD_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        st_we        = 1'b0;
        st_waddr     = ADDR_W'(count_reg);
        st_wdata     = '0;
        st_raddr     = ADDR_W'(cnt_m1);
        var_we       = 1'b0;
        div_start    = 1'b0;
        div_dvd_load = a_scaled;
        div_dvs_load = b_pop[31] ? 32'(-b_pop) : 32'(b_pop);
        div_neg_load = a_pop[31] ^ b_pop[31];
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FILL1;
                case (item_reg.command)
                    CMD_PUSH:
                    begin
                        status_next = ST_OK;
                        if (count_reg < FULL_CNT)
                        begin
                            st_we      = 1'b1;
                            st_wdata   = item_reg.value;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                            status_next = ST_FULL;
                    end
                    CMD_ADD, CMD_SUB:
                    begin
                        status_next = has2 ? ST_OK : ST_EMPTY;
                        st_we       = 1'b1;
                        st_waddr    = ADDR_W'(cnt_after2);
                        st_wdata    = addsub;
                        count_next  = cnt_after2 + CNT_W'(1);
                    end
                    CMD_MUL:
                    begin
                        status_next = has2 ? ST_OK : ST_EMPTY;
                        count_next  = cnt_after2;
                        state_next  = S_MUL2;
                    end
                    CMD_DIV:
                    begin
                        if (b_pop == '0)
                        begin
                            status_next = has1 ? ST_DIV0 : ST_EMPTY;
                            count_next  = cnt_after1;
                        end
                        else
                        begin
                            status_next = has2 ? ST_OK : ST_EMPTY;
                            count_next  = cnt_after2;
                            div_start   = 1'b1;
                            state_next  = S_DIV;
                        end
                    end
                    CMD_MOD:
                    begin
                        div_dvd_load = DVD_W'(a_int[32] ? 33'(-a_int) : a_int);
                        div_dvs_load = 32'(b_int[32] ? 33'(-b_int) : b_int);
                        div_neg_load = a_int[32];
                        if (b_int == '0)
                        begin
                            status_next = has1 ? ST_DIV0 : ST_EMPTY;
                            count_next  = cnt_after1;
                        end
                        else
                        begin
                            status_next = has2 ? ST_OK : ST_EMPTY;
                            count_next  = cnt_after2;
                            div_start   = 1'b1;
                            state_next  = S_DIV;
                        end
                    end
                    CMD_DUP:
                    begin
                        status_next = ST_OK;
                        if (!has1)
                            status_next = ST_EMPTY;
                        else if (count_reg == FULL_CNT)
                            status_next = ST_FULL;
                        else
                        begin
                            st_we      = 1'b1;
                            st_wdata   = top_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_SWAP:
                    begin
                        status_next = ST_OK;
                        if (!has2)
                            status_next = ST_EMPTY;
                        else
                        begin
                            st_we      = 1'b1;
                            st_waddr   = ADDR_W'(cnt_m1);
                            st_wdata   = sec_reg;
                            state_next = S_SWAP2;
                        end
                    end
                    CMD_STORE:
                    begin
                        status_next = has1 ? ST_OK : ST_EMPTY;
                        count_next  = cnt_after1;
                        if (idx_ok)
                            var_we = 1'b1;
                        else if (has1)
                            status_next = ST_UNSET;
                    end
                    CMD_LOAD:
                    begin
                        status_next = ST_OK;
                        if (idx_ok && var_valid_reg[VAR_AW'(item_reg.var_index)])
                            state_next = S_LOAD2;
                        else
                            status_next = ST_UNSET;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_MUL2:
            begin
                st_we      = 1'b1;
                st_wdata   = mul_res;
                count_next = count_reg + CNT_W'(1);
                state_next = S_FILL1;
            end
            S_DIV:
            begin
                if (div_ctr_reg == ITER_W'(DVD_W - 1))
                    state_next = S_DIVFIN;
            end
            S_DIVFIN:
            begin
                st_we      = 1'b1;
                st_wdata   = div_mod_reg ? mod_res : div_res;
                count_next = count_reg + CNT_W'(1);
                state_next = S_FILL1;
            end
            S_SWAP2:
            begin
                st_we      = 1'b1;
                st_waddr   = ADDR_W'(cnt_m2);
                st_wdata   = top_reg;
                state_next = S_FILL1;
            end
            S_LOAD2:
            begin
                if (count_reg < FULL_CNT)
                begin
                    st_we      = 1'b1;
                    st_wdata   = var_rdata;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                    status_next = ST_FULL;
                state_next = S_FILL1;
            end
            S_FILL1:
            begin
                state_next = S_FILL2;
            end
            S_FILL2:
            begin
                st_raddr   = ADDR_W'(cnt_m2);
                state_next = S_FILL3;
            end
            S_FILL3:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            var_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            if (var_we)
                var_valid_reg[VAR_AW'(item_reg.var_index)] <= 1'b1;
            // drop the result once taken, load a new one when done
            if (state_reg == S_DONE && (!res_valid_reg || !res_stall))
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            item_reg <= cmd;
        if (state_reg == S_EXEC)
            prod_reg <= a_pop * b_pop;
        if (state_reg == S_FILL2)
            top_reg <= st_rdata;
        if (state_reg == S_FILL3)
            sec_reg <= st_rdata;
        if (state_reg == S_DONE && (!res_valid_reg || !res_stall))
        begin
            res_reg.top_value    <= has1 ? top_reg : '0;
            res_reg.second_value <= has2 ? sec_reg : '0;
            res_reg.depth        <= 7'(count_reg);
            res_reg.status       <= status_reg;
        end
        if (div_start)
        begin
            div_q_reg   <= div_dvd_load;
            div_rem_reg <= '0;
            div_dvs_reg <= div_dvs_load;
            div_neg_reg <= div_neg_load;
            div_mod_reg <= (item_reg.command == CMD_MOD);
            div_ctr_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            div_q_reg   <= div_q_next;
            div_rem_reg <= div_rem_next;
            div_ctr_reg <= div_ctr_reg + ITER_W'(1);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("stack count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVFIN) |-> ($past(state_reg) == S_DIV))
        else $error("divider finished without iterating");

endmodule

@@ rtl/rpnc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
